@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertion helpers with active-low reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// expression never true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ src/mcfe_pkg.sv @@
// ----------------------------------------------------------------------------
// mcfe_pkg
// shared types, codes and the crc update for the motor command frame encoder
// ----------------------------------------------------------------------------
package mcfe_pkg;

  // command kinds on the input
  localparam logic [1:0] KIND_STOP  = 2'd0;
  localparam logic [1:0] KIND_SPEED = 2'd1;
  localparam logic [1:0] KIND_ANGLE = 2'd2;

  // frame bytes
  localparam logic [7:0] FRAME_HEADER = 8'h3E;
  localparam logic [7:0] CODE_STOP    = 8'h50;
  localparam logic [7:0] CODE_SPEED   = 8'h54;
  localparam logic [7:0] CODE_ANGLE   = 8'h56;
  localparam logic [7:0] LEN_DATA     = 8'h02;
  localparam logic [7:0] LEN_NONE     = 8'h00;

  // crc-16/modbus
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // byte positions inside one frame
  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] POS_HDR    = 4'd0;
  localparam logic [POS_W-1:0] POS_SEQ    = 4'd1;
  localparam logic [POS_W-1:0] POS_ID     = 4'd2;
  localparam logic [POS_W-1:0] POS_CODE   = 4'd3;
  localparam logic [POS_W-1:0] POS_LEN    = 4'd4;
  localparam logic [POS_W-1:0] POS_VAL_LO = 4'd5;
  localparam logic [POS_W-1:0] POS_VAL_HI = 4'd6;
  localparam logic [POS_W-1:0] POS_CRC_LO = 4'd7;
  localparam logic [POS_W-1:0] POS_CRC_HI = 4'd8;

  // register indexes
  localparam logic REG_LEFT_ID  = 1'b0;
  localparam logic REG_RIGHT_ID = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic             load;   // latch a new command
    logic             step;   // emit one byte into the output register
    logic [POS_W-1:0] pos;    // byte position within the frame
    logic             sel;    // 0 left frame, 1 right frame
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic kind_ok;            // input kind is a known command
    logic has_data;           // latched command carries a value
  } stat_t;

  // one byte through the bit-serial crc
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ src/mcfe_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcfe_ctrl
// sequencer over the two frames of one command and output valid tracking
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcfe_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  mcfe_pkg::stat_t stat,
  output mcfe_pkg::cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEND = 1'b1;

  logic                       state_r, state_nxt;
  logic [mcfe_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                       sel_r, sel_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       accept;
  logic                       step;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  // a byte moves when the output register is free or being drained
  assign step      = (state_r == ST_SEND) && (!out_valid_r || out_ready);

  assign cmd.load = accept;
  assign cmd.step = step;
  assign cmd.pos  = pos_r;
  assign cmd.sel  = sel_r;

  // next state and byte position
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (step) begin
      out_valid_nxt = 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept && stat.kind_ok) begin
          state_nxt = ST_SEND;
          pos_nxt   = mcfe_pkg::POS_HDR;
          sel_nxt   = 1'b0;
        end
      end
      ST_SEND: begin
        if (step) begin
          if (pos_r == mcfe_pkg::POS_CRC_HI) begin
            pos_nxt = mcfe_pkg::POS_HDR;
            sel_nxt = 1'b1;
            if (sel_r) begin
              state_nxt = ST_IDLE;
            end
          end else if (pos_r == mcfe_pkg::POS_LEN && !stat.has_data) begin
            pos_nxt = mcfe_pkg::POS_CRC_LO;
          end else begin
            pos_nxt = pos_r + mcfe_pkg::POS_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= mcfe_pkg::POS_HDR;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // checks
  `ASSERT_NEVER(a_pos_range, clk, rst_n, pos_r > mcfe_pkg::POS_CRC_HI)
  `ASSERT_CLK(a_start, clk, rst_n,
    accept && stat.kind_ok |=> state_r == ST_SEND && pos_r == mcfe_pkg::POS_HDR && !sel_r)
  `ASSERT_CLK(a_done, clk, rst_n,
    step && sel_r && pos_r == mcfe_pkg::POS_CRC_HI |=> state_r == ST_IDLE)
  `ASSERT_CLK(a_step_valid, clk, rst_n, step |=> out_valid_r)

endmodule

@@ src/mcfe_dp.sv @@
// ----------------------------------------------------------------------------
// mcfe_dp
// command latch, byte select, serial crc and output byte register
// ----------------------------------------------------------------------------
module mcfe_dp (
  input  logic            clk,
  input  logic [1:0]      in_kind,
  input  logic [15:0]     in_left_value,
  input  logic [15:0]     in_right_value,
  input  logic [7:0]      left_id,
  input  logic [7:0]      right_id,
  input  mcfe_pkg::cmd_t  cmd,
  output mcfe_pkg::stat_t stat,
  output logic [7:0]      out_tx_byte,
  output logic            out_motor_select,
  output logic            out_frame_end,
  output logic            out_last
);

  logic [7:0]  code_r;
  logic        has_data_r;
  logic [15:0] left_val_r;
  logic [15:0] right_val_r;
  logic [15:0] crc_r;
  logic [7:0]  tx_byte_r;
  logic        sel_out_r;
  logic        end_r;
  logic        last_r;
  logic [7:0]  code_sel;
  logic [7:0]  id_cur;
  logic [15:0] val_cur;
  logic [7:0]  byte_cur;

  // decode the incoming kind
  always_comb begin
    case (in_kind)
      mcfe_pkg::KIND_STOP:  code_sel = mcfe_pkg::CODE_STOP;
      mcfe_pkg::KIND_SPEED: code_sel = mcfe_pkg::CODE_SPEED;
      mcfe_pkg::KIND_ANGLE: code_sel = mcfe_pkg::CODE_ANGLE;
      default:              code_sel = mcfe_pkg::CODE_STOP;
    endcase
  end

  assign stat.kind_ok  = (in_kind == mcfe_pkg::KIND_STOP) ||
                         (in_kind == mcfe_pkg::KIND_SPEED) ||
                         (in_kind == mcfe_pkg::KIND_ANGLE);
  assign stat.has_data = has_data_r;

  // byte for the current position
  assign id_cur  = cmd.sel ? right_id : left_id;
  assign val_cur = cmd.sel ? right_val_r : left_val_r;

  always_comb begin
    case (cmd.pos)
      mcfe_pkg::POS_HDR:    byte_cur = mcfe_pkg::FRAME_HEADER;
      mcfe_pkg::POS_SEQ:    byte_cur = id_cur;
      mcfe_pkg::POS_ID:     byte_cur = id_cur;
      mcfe_pkg::POS_CODE:   byte_cur = code_r;
      mcfe_pkg::POS_LEN:    byte_cur = has_data_r ? mcfe_pkg::LEN_DATA : mcfe_pkg::LEN_NONE;
      mcfe_pkg::POS_VAL_LO: byte_cur = val_cur[7:0];
      mcfe_pkg::POS_VAL_HI: byte_cur = val_cur[15:8];
      mcfe_pkg::POS_CRC_LO: byte_cur = crc_r[7:0];
      mcfe_pkg::POS_CRC_HI: byte_cur = crc_r[15:8];
      default:              byte_cur = mcfe_pkg::FRAME_HEADER;
    endcase
  end

  // command latch, left value negated with wrap
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_r      <= code_sel;
      has_data_r  <= (in_kind != mcfe_pkg::KIND_STOP);
      left_val_r  <= 16'h0000 - in_left_value;
      right_val_r <= in_right_value;
    end
  end

  // crc runs over header to value, restarts for each frame
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      crc_r <= mcfe_pkg::CRC_INIT;
    end else if (cmd.step) begin
      if (cmd.pos == mcfe_pkg::POS_CRC_HI) begin
        crc_r <= mcfe_pkg::CRC_INIT;
      end else if (cmd.pos != mcfe_pkg::POS_CRC_LO) begin
        crc_r <= mcfe_pkg::crc_byte(crc_r, byte_cur);
      end
    end
  end

  // output byte register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      tx_byte_r <= byte_cur;
      sel_out_r <= cmd.sel;
      end_r     <= (cmd.pos == mcfe_pkg::POS_CRC_HI);
      last_r    <= (cmd.pos == mcfe_pkg::POS_CRC_HI) && cmd.sel;
    end
  end

  assign out_tx_byte      = tx_byte_r;
  assign out_motor_select = sel_out_r;
  assign out_frame_end    = end_r;
  assign out_last         = last_r;

endmodule

@@ src/motor_command_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// motor_command_frame_encoder
// turns one motor command into a left and a right crc-16/modbus frame
// ----------------------------------------------------------------------------
// Each accepted command produces one output beat per frame byte: 14 beats for
// stop, 18 for speed or angle, left frame first. The sequencer emits one byte
// per cycle into a single output register while the output is not stalled,
// and the crc is updated one byte per cycle alongside; a new command is taken
// in only once both frames of the last one have been stepped out. A command
// of unused kind 3 is accepted and dropped. Motor ids are to be written
// through the register port only while idle; the block itself does not
// enforce this.

module motor_command_frame_encoder (
  input  logic        clk,
  input  logic        rst_n,
  // command input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic signed [15:0] in_left_value,
  input  logic signed [15:0] in_right_value,
  // byte output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_motor_select,
  output logic        out_frame_end,
  output logic        out_last,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic            rd_left;
  logic [7:0]      left_id_r;
  logic [7:0]      right_id_r;
  logic            wr_en;
  mcfe_pkg::cmd_t  cmd;
  mcfe_pkg::stat_t stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // motor id registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_id_r  <= 8'd1;
      right_id_r <= 8'd2;
    end else if (wr_en) begin
      if (paddr[2] == mcfe_pkg::REG_LEFT_ID) begin
        left_id_r <= pwdata[7:0];
      end else begin
        right_id_r <= pwdata[7:0];
      end
    end
  end

  // read back
  assign rd_left = (paddr[2] == mcfe_pkg::REG_LEFT_ID);
  assign prdata  = {24'h000000, rd_left ? left_id_r : right_id_r};

  mcfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mcfe_dp u_dp (
    .clk              (clk),
    .in_kind          (in_kind),
    .in_left_value    (in_left_value),
    .in_right_value   (in_right_value),
    .left_id          (left_id_r),
    .right_id         (right_id_r),
    .cmd              (cmd),
    .stat             (stat),
    .out_tx_byte      (out_tx_byte),
    .out_motor_select (out_motor_select),
    .out_frame_end    (out_frame_end),
    .out_last         (out_last)
  );

endmodule

@@ tb/motor_command_frame_encoder_tb.sv @@
// ----------------------------------------------------------------------------
// motor_command_frame_encoder_tb
// self-checking bench for the left/right crc-16/modbus frame encoder
// ----------------------------------------------------------------------------
// Commands go in over a valid/ready channel and every output beat is compared
// with a frame builder that computes its own crc. A short table of directed
// commands (extremes, every kind, the unused kind, the -32768 wrap) runs
// first with the reset motor ids, some rows with their code, ids and beat
// count typed in. Random commands follow over several motor id settings
// written through the register port while the encoder is idle, with random
// idling on both sides, long output stalls and a full drain pause.
// ----------------------------------------------------------------------------

module motor_command_frame_encoder_tb;

  localparam logic [1:0] KIND_UNUSED    = 2'd3;
  localparam logic [7:0] RESET_LEFT_ID  = 8'h01;
  localparam logic [7:0] RESET_RIGHT_ID = 8'h02;
  localparam logic [2:0] ADDR_LEFT_ID   = {mcfe_pkg::REG_LEFT_ID, 2'b00};
  localparam logic [2:0] ADDR_RIGHT_ID  = {mcfe_pkg::REG_RIGHT_ID, 2'b00};
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_ITEMS   = 62;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 250;
  localparam int STALL_LIMIT   = 3000;
  localparam int NUM_DIRECTED  = 20;

  // one output beat
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       motor_select;
    logic       frame_end;
    logic       last;
  } frame_beat_t;

  // typed-in facts about one command's beats
  typedef struct packed {
    logic       typed;
    logic [7:0] code;
    logic [4:0] beats;
  } cmd_check_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] left_value;
    logic [15:0] right_value;
    logic        typed;
    logic [7:0]  code;
    logic [4:0]  beats;
  } dir_row_t;

  // directed commands, sent with the reset motor ids
  localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{mcfe_pkg::KIND_STOP,  16'h0000, 16'h0000, 1'b1, mcfe_pkg::CODE_STOP,  5'd14},
    '{mcfe_pkg::KIND_SPEED, 16'h0000, 16'h0000, 1'b1, mcfe_pkg::CODE_SPEED, 5'd18},
    '{mcfe_pkg::KIND_ANGLE, 16'h0000, 16'h0000, 1'b1, mcfe_pkg::CODE_ANGLE, 5'd18},
    '{mcfe_pkg::KIND_SPEED, 16'h7FFF, 16'h7FFF, 1'b1, mcfe_pkg::CODE_SPEED, 5'd18},
    '{mcfe_pkg::KIND_SPEED, 16'h8000, 16'h8000, 1'b1, mcfe_pkg::CODE_SPEED, 5'd18},
    '{mcfe_pkg::KIND_ANGLE, 16'h8000, 16'h7FFF, 1'b1, mcfe_pkg::CODE_ANGLE, 5'd18},
    '{mcfe_pkg::KIND_ANGLE, 16'h7FFF, 16'h8000, 1'b1, mcfe_pkg::CODE_ANGLE, 5'd18},
    '{mcfe_pkg::KIND_SPEED, 16'hFFFF, 16'h0001, 1'b1, mcfe_pkg::CODE_SPEED, 5'd18},
    '{mcfe_pkg::KIND_SPEED, 16'h0001, 16'hFFFF, 1'b1, mcfe_pkg::CODE_SPEED, 5'd18},
    '{KIND_UNUSED,          16'h1234, 16'h5678, 1'b0, 8'h00,                5'd0},
    '{mcfe_pkg::KIND_STOP,  16'hFFFF, 16'hFFFF, 1'b1, mcfe_pkg::CODE_STOP,  5'd14},
    '{mcfe_pkg::KIND_STOP,  16'h8000, 16'h7FFF, 1'b1, mcfe_pkg::CODE_STOP,  5'd14},
    '{KIND_UNUSED,          16'hFFFF, 16'hFFFF, 1'b0, 8'h00,                5'd0},
    '{mcfe_pkg::KIND_SPEED, 16'h00FF, 16'hFF00, 1'b0, 8'h00,                5'd0},
    '{mcfe_pkg::KIND_ANGLE, 16'hFF00, 16'h00FF, 1'b0, 8'h00,                5'd0},
    '{mcfe_pkg::KIND_SPEED, 16'h5555, 16'hAAAA, 1'b0, 8'h00,                5'd0},
    '{mcfe_pkg::KIND_ANGLE, 16'hAAAA, 16'h5555, 1'b0, 8'h00,                5'd0},
    '{KIND_UNUSED,          16'h0000, 16'h0000, 1'b0, 8'h00,                5'd0},
    '{mcfe_pkg::KIND_SPEED, 16'h1234, 16'hABCD, 1'b0, 8'h00,                5'd0},
    '{mcfe_pkg::KIND_ANGLE, 16'h0001, 16'h0000, 1'b0, 8'h00,                5'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = mcfe_pkg::KIND_STOP;
  logic [15:0] in_left_value = '0;
  logic [15:0] in_right_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_tx_byte;
  logic        out_motor_select;
  logic        out_frame_end;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // encoder's motor ids as the bench knows them
  logic [7:0]  left_id = RESET_LEFT_ID;
  logic [7:0]  right_id = RESET_RIGHT_ID;

  frame_beat_t expected_beats [$];
  cmd_check_t  cmd_checks [$];
  frame_beat_t beat_want;
  cmd_check_t  check_want;

  int errors = 0;
  int cmds_sent = 0;
  int ignored_sent = 0;
  int beats_seen = 0;
  int settings_used = 0;
  int cmd_beat_idx = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int p;
  int n;

  motor_command_frame_encoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_left_value    (in_left_value),
    .in_right_value   (in_right_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tx_byte      (out_tx_byte),
    .out_motor_select (out_motor_select),
    .out_frame_end    (out_frame_end),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  // build one frame and queue its beats
  function automatic void queue_frame(input logic [7:0] id, input logic [7:0] code,
                                      input logic with_value, input logic [15:0] value,
                                      input logic sel, input logic closes_cmd);
    logic [7:0]  bytes [9];
    logic [15:0] crc;
    int          count;
    frame_beat_t beat;
    bytes[0] = mcfe_pkg::FRAME_HEADER;
    bytes[1] = id;
    bytes[2] = id;
    bytes[3] = code;
    bytes[4] = with_value ? mcfe_pkg::LEN_DATA : mcfe_pkg::LEN_NONE;
    count = 5;
    if (with_value) begin
      bytes[5] = value[7:0];
      bytes[6] = value[15:8];
      count = 7;
    end
    // reflected crc, shifting out one bit at a time
    crc = mcfe_pkg::CRC_INIT;
    for (int i = 0; i < count; i++) begin
      crc = crc ^ {8'h00, bytes[i]};
      repeat (8) crc = crc[0] ? ((crc >> 1) ^ mcfe_pkg::CRC_POLY) : (crc >> 1);
    end
    bytes[count] = crc[7:0];
    bytes[count + 1] = crc[15:8];
    count = count + 2;
    for (int i = 0; i < count; i++) begin
      beat.tx_byte = bytes[i];
      beat.motor_select = sel;
      beat.frame_end = (i == count - 1);
      beat.last = (i == count - 1) && closes_cmd;
      expected_beats.push_back(beat);
    end
  endfunction

  // expected beats of one command
  function automatic void predict_command(input logic [1:0] kind, input logic [15:0] lv,
                                          input logic [15:0] rv);
    logic [7:0]  code;
    logic        with_value;
    logic [15:0] left_neg;
    case (kind)
      mcfe_pkg::KIND_STOP: begin
        code = mcfe_pkg::CODE_STOP;
        with_value = 1'b0;
      end
      mcfe_pkg::KIND_SPEED: begin
        code = mcfe_pkg::CODE_SPEED;
        with_value = 1'b1;
      end
      mcfe_pkg::KIND_ANGLE: begin
        code = mcfe_pkg::CODE_ANGLE;
        with_value = 1'b1;
      end
      default: return;
    endcase
    left_neg = 16'h0000 - lv;
    queue_frame(left_id, code, with_value, left_neg, 1'b0, 1'b0);
    queue_frame(right_id, code, with_value, rv, 1'b1, 1'b1);
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(19))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // offer one command and wait for its handshake
  task automatic send_command(input logic [1:0] kind, input logic [15:0] lv,
                              input logic [15:0] rv, input cmd_check_t check);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_left_value <= lv;
    in_right_value <= rv;
    do @(posedge clk); while (!in_ready);
    predict_command(kind, lv, rv);
    if (kind == KIND_UNUSED) begin
      ignored_sent++;
    end else begin
      cmd_checks.push_back(check);
      cmds_sent++;
    end
  endtask

  // stop offering and let every expected beat come out
  task automatic drain_output();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_motor_ids(input logic [7:0] lid, input logic [7:0] rid);
    // upper bits are junk, only the low byte counts
    write_reg(ADDR_LEFT_ID, {24'($urandom), lid});
    left_id = lid;
    write_reg(ADDR_RIGHT_ID, {24'($urandom), rid});
    right_id = rid;
    settings_used++;
  endtask

  // receiver: random ready, long hold-off on request
  always @(posedge clk) begin
    if (hold_left == 0 && holds_done != hold_requests) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each output beat with the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        errors++;
        $error("unexpected beat: tx_byte %02h motor_select %0b", out_tx_byte,
               out_motor_select);
      end else begin
        beat_want = expected_beats.pop_front();
        if (out_tx_byte !== beat_want.tx_byte) begin
          errors++;
          $error("tx_byte: expected %02h, got %02h", beat_want.tx_byte, out_tx_byte);
        end
        if (out_motor_select !== beat_want.motor_select) begin
          errors++;
          $error("motor_select: expected %0b, got %0b", beat_want.motor_select,
                 out_motor_select);
        end
        if (out_frame_end !== beat_want.frame_end) begin
          errors++;
          $error("frame_end: expected %0b, got %0b", beat_want.frame_end, out_frame_end);
        end
        if (out_last !== beat_want.last) begin
          errors++;
          $error("last: expected %0b, got %0b", beat_want.last, out_last);
        end
        // typed-in code, ids and beat count of directed rows
        if (cmd_checks.size() != 0) begin
          check_want = cmd_checks[0];
          if (check_want.typed) begin
            if ((cmd_beat_idx == 3 || cmd_beat_idx == check_want.beats / 2 + 3) &&
                out_tx_byte !== check_want.code) begin
              errors++;
              $error("tx_byte (code): expected %02h, got %02h", check_want.code,
                     out_tx_byte);
            end
            if ((cmd_beat_idx == 1 || cmd_beat_idx == 2) && out_tx_byte !== RESET_LEFT_ID)
              begin
              errors++;
              $error("tx_byte (left id): expected %02h, got %02h", RESET_LEFT_ID,
                     out_tx_byte);
            end
            if ((cmd_beat_idx == check_want.beats / 2 + 1 ||
                 cmd_beat_idx == check_want.beats / 2 + 2) &&
                out_tx_byte !== RESET_RIGHT_ID) begin
              errors++;
              $error("tx_byte (right id): expected %02h, got %02h", RESET_RIGHT_ID,
                     out_tx_byte);
            end
            if (beat_want.last && cmd_beat_idx + 1 != check_want.beats) begin
              errors++;
              $error("beat count: expected %0d, got %0d", check_want.beats,
                     cmd_beat_idx + 1);
            end
          end
          if (beat_want.last) begin
            void'(cmd_checks.pop_front());
            cmd_beat_idx = 0;
          end else begin
            cmd_beat_idx++;
          end
        end
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles", stall_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [7:0]  lid_list [NUM_PHASES];
    logic [7:0]  rid_list [NUM_PHASES];
    logic [1:0]  kind;
    cmd_check_t  check;
    lid_list = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'($urandom), 8'($urandom)};
    rid_list = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'($urandom), 8'($urandom)};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table with reset ids, sender 34 / receiver 53
    send_idle_pct = 34;
    recv_idle_pct = 53;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      check.typed = DIRECTED_ROWS[i].typed;
      check.code = DIRECTED_ROWS[i].code;
      check.beats = DIRECTED_ROWS[i].beats;
      send_command(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].left_value,
                   DIRECTED_ROWS[i].right_value, check);
    end

    // random commands over several id settings
    check = '0;
    for (p = 0; p < NUM_PHASES; p++) begin
      drain_output();
      set_motor_ids(lid_list[p], rid_list[p]);
      if (p < 2) begin
        send_idle_pct = 34;
        recv_idle_pct = 53;
      end else if (p < 4) begin
        send_idle_pct = 53;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      n = 0;
      while (n < PHASE_ITEMS) begin
        kind = ($urandom_range(99) < 8) ? KIND_UNUSED : 2'($urandom_range(2));
        send_command(kind, pick_value(), pick_value(), check);
        if (kind != KIND_UNUSED) begin
          n++;
          // long output stall while commands keep coming
          if ((p == 1 || p == 4) && n == 10)
            hold_requests++;
          // sender waits for the stream to run dry
          if (p == 1 && n == PHASE_ITEMS / 2)
            drain_output();
        end
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d commands plus %0d of unused kind, %0d output beats",
             cmds_sent, ignored_sent, beats_seen);
    $display("over %0d motor id settings, with idling on both sides and long stalls",
             settings_used + 1);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
